FILE: rtl/bspc_pkg.sv
// Shared types and constants for the biallelic site pattern compressor.
// Used by the top level biallelic_site_pattern_compressor.
package bspc_pkg;

    // Result error codes.
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_POLY_STD    = 3'd1;
    localparam logic [2:0] ERR_CODE2_HAPL  = 3'd2;
    localparam logic [2:0] ERR_MANY_STATES = 3'd3;
    localparam logic [2:0] ERR_POLY_HAPL   = 3'd4;
    localparam logic [2:0] ERR_THIRD       = 3'd5;
    localparam logic [2:0] ERR_TABLE_FULL  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIPLOID    = 2'd0;
    localparam logic [1:0] REG_NUCLEOTIDE = 2'd1;
    localparam logic [1:0] REG_POP_COUNT  = 2'd2;

    localparam int WEIGHT_W = 24;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_COMPARE,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/bspc_cell.sv
// One population cell: holds the red and total allele counts of the site.
// Compares its counts against a table word slice and passes the match along.
module bspc_cell #(
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_add_en,
    input  logic [1:0]            i_add_red,
    input  logic [1:0]            i_add_tot,
    input  logic                  i_clear,
    input  logic [COUNT_BITS-1:0] i_ref_red,
    input  logic [COUNT_BITS-1:0] i_ref_tot,
    input  logic                  i_match,
    output logic                  o_match,
    output logic [COUNT_BITS-1:0] o_red,
    output logic [COUNT_BITS-1:0] o_tot
);

    localparam logic [COUNT_BITS:0] CNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    logic [COUNT_BITS-1:0] r_red, n_red, r_tot, n_tot;
    logic [COUNT_BITS:0]   w_red_sum, w_tot_sum;

    // Saturating accumulation.
    assign w_red_sum = {1'b0, r_red} + {{(COUNT_BITS-1){1'b0}}, i_add_red};
    assign w_tot_sum = {1'b0, r_tot} + {{(COUNT_BITS-1){1'b0}}, i_add_tot};

    always_comb begin
        n_red = r_red;
        n_tot = r_tot;
        if (i_clear) begin
            n_red = '0;
            n_tot = '0;
        end else if (i_add_en) begin
            n_red = (w_red_sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : w_red_sum[COUNT_BITS-1:0];
            n_tot = (w_tot_sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : w_tot_sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red <= '0;
            r_tot <= '0;
        end else begin
            r_red <= n_red;
            r_tot <= n_tot;
        end
    end

    // Match chain link.
    assign o_match = i_match && (r_red == i_ref_red) && (r_tot == i_ref_tot);
    assign o_red   = r_red;
    assign o_tot   = r_tot;

endmodule

FILE: rtl/biallelic_site_pattern_compressor.sv
// Top level of the biallelic site pattern compressor; uses bspc_pkg and bspc_cell.
// Holds the pattern table memory, allele tracking and the search sequencer.
//
// Each genotype word is taken by a row of population cells. On the word marked tlast
// the site's count pattern is searched in the table, one stored pattern at a time,
// each through an issue state and a compare state (one memory read port, registered
// read data). A voided site skips the search and goes straight to the done state. No
// words are taken during the search, nor while the result waits for the previous one
// to leave the output register. The table needs no clearing after reset.
module biallelic_site_pattern_compressor #(
    parameter int MAX_POPULATIONS = 8,
    parameter int MAX_PATTERNS    = 1024,
    parameter int COUNT_BITS      = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // pop_index[2:0], state_count[4:3], first_state[6:5],
                                    // second_state[8:7], zeros[15:9]
    input  logic        i_s_tlast,  // site_end
    // Result words.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // pattern_slot[9:0], pattern_found[10],
                                    // pattern_weight[34:11], error_code[37:35], zeros[39:38]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bspc_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PATTERNS);
    localparam int FILL_W = SLOT_W + 1;
    localparam int PAT_W  = MAX_POPULATIONS * COUNT_BITS;
    localparam int WORD_W = 2 * PAT_W + WEIGHT_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERNS);
    localparam logic [4:0]        POPS_MAX = 5'(MAX_POPULATIONS);

    // Configuration registers.
    logic       r_diploid, r_nucleotide;
    logic [3:0] r_pop_count;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diploid    <= 1'b0;
            r_nucleotide <= 1'b0;
            r_pop_count  <= 4'd1;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_DIPLOID:    r_diploid    <= pwdata[0];
                REG_NUCLEOTIDE: r_nucleotide <= pwdata[0];
                REG_POP_COUNT:  r_pop_count  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DIPLOID:    prdata = {31'd0, r_diploid};
            REG_NUCLEOTIDE: prdata = {31'd0, r_nucleotide};
            REG_POP_COUNT:  prdata = {28'd0, r_pop_count};
            default:        prdata = 32'd0;
        endcase
    end

    // Input fields.
    logic [2:0] w_pop;
    logic [1:0] w_n, w_s0, w_s1;
    assign w_pop = i_s_tdata[2:0];
    assign w_n   = i_s_tdata[4:3];
    assign w_s0  = i_s_tdata[6:5];
    assign w_s1  = i_s_tdata[8:7];

    t_state r_state, n_state;
    logic   w_in_acc, w_pop_ok, w_take, w_clear;
    logic   w_load_out;

    assign w_in_acc = i_s_tvalid && o_s_tready;

    // Site state: allele labels and first error.
    logic       r_gv, r_rv;
    logic [1:0] r_g, r_r;
    logic [2:0] r_site_err;

    // Cell classification, including allele labelling for nucleotide data.
    logic [2:0] c_err;
    logic [1:0] c_add_r, c_add_t, c_m, c_code;
    logic       c_gv, c_rv;
    logic [1:0] c_g, c_r;

    always_comb begin
        c_err   = ERR_OK;
        c_add_r = 2'd0;
        c_add_t = 2'd0;
        c_gv    = r_gv;
        c_rv    = r_rv;
        c_g     = r_g;
        c_r     = r_r;
        c_m     = 2'd1;
        c_code  = w_s0;
        if (w_n == 2'd0) begin
            c_err = ERR_OK;
        end else if (!r_nucleotide) begin
            if (w_n > 2'd1) begin
                c_err = ERR_POLY_STD;
            end else if (w_s0 == 2'd3) begin
                c_err = ERR_MANY_STATES;
            end else if (w_s0 == 2'd2 && !r_diploid) begin
                c_err = ERR_CODE2_HAPL;
            end else begin
                c_add_r = w_s0;
                c_add_t = r_diploid ? 2'd2 : 2'd1;
            end
        end else if (w_n == 2'd3) begin
            c_err = ERR_MANY_STATES;
        end else if (w_n == 2'd2 && !r_diploid) begin
            c_err = ERR_POLY_HAPL;
        end else begin
            c_m = (w_n == 2'd2) ? 2'd1 : (r_diploid ? 2'd2 : 2'd1);
            for (int k = 0; k < 2; k++) begin
                if (k == 0 || (w_n == 2'd2 && c_err == ERR_OK)) begin
                    c_code = (k == 0) ? w_s0 : w_s1;
                    if (!c_gv) begin
                        c_gv    = 1'b1;
                        c_g     = c_code;
                        c_add_t = c_add_t + c_m;
                    end else if (c_g == c_code) begin
                        c_add_t = c_add_t + c_m;
                    end else if (!c_rv || c_r == c_code) begin
                        c_rv    = 1'b1;
                        c_r     = c_code;
                        c_add_r = c_add_r + c_m;
                        c_add_t = c_add_t + c_m;
                    end else begin
                        c_err = ERR_THIRD;
                    end
                end
            end
        end
    end

    // A cell counts when the site is still clean and its population is in use.
    assign w_pop_ok = ({2'b00, w_pop} < ((5'({1'b0, r_pop_count}) > POPS_MAX) ?
                                         POPS_MAX : 5'({1'b0, r_pop_count})));
    assign w_take   = w_in_acc && (r_site_err == ERR_OK) && w_pop_ok;

    logic [2:0] w_final_err;
    assign w_final_err = (w_take && c_err != ERR_OK) ? c_err : r_site_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_gv       <= 1'b0;
            r_rv       <= 1'b0;
            r_g        <= 2'd0;
            r_r        <= 2'd0;
            r_site_err <= ERR_OK;
        end else if (w_take) begin
            r_site_err <= c_err;
            if (c_err == ERR_OK) begin
                r_gv <= c_gv;
                r_rv <= c_rv;
                r_g  <= c_g;
                r_r  <= c_r;
            end
        end
    end

    // Row of population cells.
    logic [MAX_POPULATIONS:0]   w_match;
    logic [PAT_W-1:0]           w_red_pat, w_tot_pat;
    logic [WORD_W-1:0]          r_rd;

    assign w_match[0] = 1'b1;

    for (genvar gi = 0; gi < MAX_POPULATIONS; gi++) begin : g_cell
        bspc_cell #(
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_add_en (w_take && c_err == ERR_OK && {1'b0, w_pop} == 4'(gi)),
            .i_add_red(c_add_r),
            .i_add_tot(c_add_t),
            .i_clear  (w_clear),
            .i_ref_red(r_rd[gi*COUNT_BITS +: COUNT_BITS]),
            .i_ref_tot(r_rd[PAT_W + gi*COUNT_BITS +: COUNT_BITS]),
            .i_match  (w_match[gi]),
            .o_match  (w_match[gi+1]),
            .o_red    (w_red_pat[gi*COUNT_BITS +: COUNT_BITS]),
            .o_tot    (w_tot_pat[gi*COUNT_BITS +: COUNT_BITS])
        );
    end

    // Pattern table: patterns and weight in one word.
    logic [WORD_W-1:0]   r_mem [MAX_PATTERNS];
    logic [FILL_W-1:0]   r_fill, r_idx;
    logic                w_rd_en, w_wr_en;
    logic [SLOT_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0]   w_wr_data;
    logic [WEIGHT_W-1:0] w_old_w, w_new_w;

    assign w_old_w = r_rd[2*PAT_W +: WEIGHT_W];
    assign w_new_w = (w_old_w == WEIGHT_MAX) ? w_old_w : w_old_w + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[r_idx[SLOT_W-1:0]];
        end
    end

    // Result holding registers.
    logic [FILL_W-1:0]   r_res_slot;
    logic                r_res_found;
    logic [WEIGHT_W-1:0] r_res_w;
    logic [2:0]          r_res_err;
    logic                r_ovalid;
    logic [9:0]          r_oslot;
    logic                r_ofound;
    logic [WEIGHT_W-1:0] r_ow;
    logic [2:0]          r_oerr;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_s_tlast) begin
                    n_state = (w_final_err != ERR_OK) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = (r_idx == r_fill) ? ST_DONE : ST_COMPARE;
            end
            ST_COMPARE: begin
                n_state = w_match[MAX_POPULATIONS] ? ST_DONE : ST_ISSUE;
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output and control logic of the sequencer.
    always_comb begin
        o_s_tready = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_idx[SLOT_W-1:0];
        w_wr_data  = {w_new_w, r_rd[2*PAT_W-1:0]};
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_ISSUE: begin
                w_rd_en = (r_idx != r_fill);
                if (r_idx == r_fill && r_fill != FILL_MAX) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {WEIGHT_W'(1), w_tot_pat, w_red_pat};
                end
            end
            ST_COMPARE: begin
                w_wr_en = w_match[MAX_POPULATIONS];
            end
            ST_DONE: begin
                w_load_out = !r_ovalid || i_m_tready;
            end
            default: ;
        endcase
    end

    assign w_clear = w_load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                end
                ST_ISSUE: begin
                    if (r_idx == r_fill && r_fill != FILL_MAX) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                ST_COMPARE: begin
                    if (!w_match[MAX_POPULATIONS]) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result fields, settled before ST_DONE.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_res_slot  <= '0;
                r_res_found <= 1'b0;
                r_res_w     <= '0;
                r_res_err   <= w_final_err;
            end
            ST_ISSUE: begin
                if (r_idx == r_fill) begin
                    if (r_fill != FILL_MAX) begin
                        r_res_slot <= r_fill;
                        r_res_w    <= WEIGHT_W'(1);
                    end else begin
                        r_res_err  <= ERR_TABLE_FULL;
                    end
                end
            end
            ST_COMPARE: begin
                if (w_match[MAX_POPULATIONS]) begin
                    r_res_slot  <= r_idx;
                    r_res_found <= 1'b1;
                    r_res_w     <= w_new_w;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_oslot  <= 10'(r_res_slot);
            r_ofound <= r_res_found;
            r_ow     <= r_res_w;
            r_oerr   <= r_res_err;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oerr, r_ow, r_ofound, r_oslot};

    // Checks.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("pattern fill beyond table size");

    a_cmp_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPARE) |-> (r_idx < r_fill))
        else $error("compare of an unfilled slot");

    a_err_no_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr != ERR_OK) |-> (r_ow == '0 && !r_ofound))
        else $error("voided site carries a weight");

    a_found_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofound) |-> (r_ow != '0))
        else $error("found pattern with zero weight");

endmodule
